// ===== hw/rtl/i64div_pkg.sv =====
// ----------------------------------------------------------------------------
// i64div_pkg
// Shared types and constants of the signed/unsigned restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

package i64div_pkg;

  // operand width used by the arithmetic, at most FIELD_WIDTH
  localparam int DATA_WIDTH  = 64;
  // width of the dividend, divisor, quotient and remainder fields
  localparam int FIELD_WIDTH = 64;
  // step counter width, indexes steps 0 .. DATA_WIDTH-1
  localparam int CNT_WIDTH   = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  // request type codes
  localparam logic REQ_UNSIGNED = 1'b0;
  localparam logic REQ_SIGNED   = 1'b1;

  typedef logic [DATA_WIDTH-1:0]  word_t;
  typedef logic [FIELD_WIDTH-1:0] field_t;
  typedef logic [CNT_WIDTH-1:0]   cnt_t;

endpackage

`default_nettype wire

// ===== hw/rtl/i64div_if.sv =====
// ----------------------------------------------------------------------------
// i64div request and response channels
// Valid/ready channels carrying the divider's operands and its results.
// ----------------------------------------------------------------------------
`default_nettype none

interface i64div_req_if;
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  i64div_pkg::field_t     dividend;
  i64div_pkg::field_t     divisor;

  modport source (output valid, output req_type, output dividend, output divisor,
                  input ready);
  modport sink   (input valid, input req_type, input dividend, input divisor,
                  output ready);
endinterface

interface i64div_rsp_if;
  logic                   valid;
  logic                   ready;
  i64div_pkg::field_t     quotient;
  i64div_pkg::field_t     remainder;
  logic                   div_by_zero;

  modport source (output valid, output quotient, output remainder, output div_by_zero,
                  input ready);
  modport sink   (input valid, input quotient, input remainder, input div_by_zero,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/i64div_core.sv =====
// ----------------------------------------------------------------------------
// i64div_core
// Unsigned restoring divider: the dividend shifts out of the top of a
// shift register one bit per cycle into the partial remainder while the
// quotient bits shift in at the bottom. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module i64div_core (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  i64div_pkg::word_t   num,
  input  i64div_pkg::word_t   den,
  output logic                done,
  output i64div_pkg::word_t   quo,
  output i64div_pkg::word_t   rem
);

  localparam int DW = i64div_pkg::DATA_WIDTH;

  i64div_pkg::word_t rem_reg;
  i64div_pkg::word_t shift_reg;
  i64div_pkg::word_t den_reg;
  i64div_pkg::cnt_t  cnt;
  logic              busy;

  logic [DW:0]       trial;
  logic [DW+1:0]     diff;
  logic              fits;
  i64div_pkg::word_t rem_next;
  i64div_pkg::word_t shift_next;

  // shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem_reg, shift_reg[DW-1]};
    diff  = {1'b0, trial} - {2'b00, den_reg};
    fits  = ~diff[DW+1];
    if (fits) begin
      rem_next = diff[DW-1:0];
    end else begin
      rem_next = trial[DW-1:0];
    end
    shift_next = {shift_reg[DW-2:0], fits};
  end

  // step sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= i64div_pkg::cnt_t'(DW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_reg   <= '0;
      shift_reg <= num;
      den_reg   <= den;
    end else if (busy) begin
      rem_reg   <= rem_next;
      shift_reg <= shift_next;
    end
  end

  assign quo = shift_reg;
  assign rem = rem_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/int64_divider_signed_unsigned.sv =====
// ----------------------------------------------------------------------------
// int64_divider_signed_unsigned
// Signed/unsigned 64-bit divider giving quotient (toward zero) and remainder
// (sign of the dividend); a zero divisor flags div_by_zero, returns an
// all-ones quotient and the dividend as remainder.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                 handshake
//   req      in   req_type, dividend, divisor             valid/ready
//   rsp      out  quotient, remainder, div_by_zero        valid/ready
//
// From acceptance to a valid result an item passes through these steps: the
// PREP state takes operand magnitudes and starts the core, the shift-subtract
// core runs 64 quotient-bit steps, the sign fix-up is registered as the core
// finishes, and the result is loaded into the output register. A zero divisor
// skips the core. One item at a time; the next is accepted the cycle after the
// result has moved into the output register, even while that result is still stalled.
// Reset (rst, synchronous) empties the block and drops any item in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module int64_divider_signed_unsigned (
  input  wire             clk,
  input  wire             rst,
  i64div_req_if.sink      req,
  i64div_rsp_if.source    rsp
);

  localparam int DW = i64div_pkg::DATA_WIDTH;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state;
  logic              op_signed;
  i64div_pkg::word_t n_raw;
  i64div_pkg::word_t d_raw;
  logic              neg_q;
  logic              neg_r;
  i64div_pkg::word_t res_q;
  i64div_pkg::word_t res_r;
  logic              res_dbz;

  logic              out_valid;
  i64div_pkg::field_t out_q;
  i64div_pkg::field_t out_r;
  logic              out_dbz;

  logic              n_neg;
  logic              d_neg;
  i64div_pkg::word_t n_mag;
  i64div_pkg::word_t d_mag;
  logic              core_start;
  logic              core_done;
  i64div_pkg::word_t core_q;
  i64div_pkg::word_t core_r;
  logic              out_load;

  // operand signs and magnitudes
  always_comb begin
    n_neg = (op_signed == i64div_pkg::REQ_SIGNED) && n_raw[DW-1];
    d_neg = (op_signed == i64div_pkg::REQ_SIGNED) && d_raw[DW-1];
    n_mag = n_neg ? (~n_raw) + i64div_pkg::word_t'(1) : n_raw;
    d_mag = d_neg ? (~d_raw) + i64div_pkg::word_t'(1) : d_raw;
  end

  assign core_start = (state == S_PREP) && (d_raw != '0);
  assign out_load   = (state == S_DONE) && (!out_valid || rsp.ready);
  assign req.ready  = (state == S_IDLE);

  i64div_core u_core (
    .clk   (clk),
    .rst   (rst),
    .start (core_start),
    .num   (n_mag),
    .den   (d_mag),
    .done  (core_done),
    .quo   (core_q),
    .rem   (core_r)
  );

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) state <= S_PREP;
        end
        S_PREP: begin
          state <= (d_raw == '0) ? S_DONE : S_RUN;
        end
        S_RUN: begin
          if (core_done) state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // operand capture, sign flags and result fix-up
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      op_signed <= req.req_type;
      n_raw     <= req.dividend[DW-1:0];
      d_raw     <= req.divisor[DW-1:0];
    end
    if (state == S_PREP) begin
      neg_q   <= n_neg ^ d_neg;
      neg_r   <= n_neg;
      res_q   <= '1;
      res_r   <= n_raw;
      res_dbz <= (d_raw == '0);
    end
    if (state == S_RUN && core_done) begin
      res_q <= neg_q ? (~core_q) + i64div_pkg::word_t'(1) : core_q;
      res_r <= neg_r ? (~core_r) + i64div_pkg::word_t'(1) : core_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_q   <= i64div_pkg::field_t'(res_q);
      out_r   <= i64div_pkg::field_t'(res_r);
      out_dbz <= res_dbz;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.quotient    = out_q;
  assign rsp.remainder   = out_r;
  assign rsp.div_by_zero = out_dbz;

endmodule

`default_nettype wire
